@@ hw/rtl/v3alu_pkg.sv @@
`timescale 1ns / 1ps

package v3alu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int LANES     = 3;

    // normalize: floor(m * 2^(2F) / s) then integer square root
    localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
    localparam int QW        = DIV_STEPS;
    localparam int SQ_STEPS  = FRAC_BITS + 1;
    localparam int SQ_IN_W   = 2 * SQ_STEPS;
    localparam int SQ_REM_W  = FRAC_BITS + 4;

    // result path delay from the shift/saturate stage to the output register
    localparam int DLY       = 3 * FRAC_BITS + 1;
    // clock edges from the accepting edge to the edge that samples done
    localparam int LATENCY   = 3 * FRAC_BITS + 6;

    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_CROSS = 3'd2,
        FN_DOT   = 3'd3,
        FN_NORM  = 3'd4
    } func_t;

    typedef struct packed {
        logic [DW-1:0] val;
        logic          ov;
    } sat_t;

    typedef struct packed {
        logic [LANES-1:0][DW-1:0] r;
        logic [DW-1:0]            sc;
        logic                     zl;
        logic                     ov;
        logic                     norm;
        logic [LANES-1:0]         neg;
    } res_t;

    function automatic sat_t sat66(input logic signed [PW+1:0] x);
        sat_t t;
        t.ov = !((&x[PW+1:DW-1]) || !(|x[PW+1:DW-1]));
        if (t.ov)
        begin
            t.val = x[PW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        else
        begin
            t.val = x[DW-1:0];
        end
        return t;
    endfunction

endpackage

@@ hw/rtl/v3alu_mul_lane.sv @@
`timescale 1ns / 1ps

module v3alu_mul_lane (
    input  logic                              clk,
    input  logic signed [v3alu_pkg::DW-1:0]   x1,
    input  logic signed [v3alu_pkg::DW-1:0]   y1,
    input  logic signed [v3alu_pkg::DW-1:0]   x2,
    input  logic signed [v3alu_pkg::DW-1:0]   y2,
    output logic signed [v3alu_pkg::PW-1:0]   p,
    output logic signed [v3alu_pkg::PW-1:0]   q
);
    import v3alu_pkg::*;

    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] q_reg;
    logic signed [PW-1:0] p_next;
    logic signed [PW-1:0] q_next;

    assign p_next = x1 * y1;
    assign q_next = x2 * y2;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
    end

    assign p = p_reg;
    assign q = q_reg;

endmodule

@@ hw/rtl/v3alu_merge.sv @@
`timescale 1ns / 1ps

module v3alu_merge (
    input  logic                              clk,
    input  v3alu_pkg::func_t                  func,
    input  logic signed [v3alu_pkg::DW:0]     as_in [v3alu_pkg::LANES],
    input  logic [v3alu_pkg::LANES-1:0]       neg,
    input  logic signed [v3alu_pkg::PW-1:0]   p [v3alu_pkg::LANES],
    input  logic signed [v3alu_pkg::PW-1:0]   q [v3alu_pkg::LANES],
    output logic [v3alu_pkg::PW-1:0]          m [v3alu_pkg::LANES],
    output logic [v3alu_pkg::PW-1:0]          s,
    output v3alu_pkg::res_t                   res
);
    import v3alu_pkg::*;

    func_t                 func_reg;
    logic signed [DW:0]    as_reg [LANES];
    logic [LANES-1:0]      neg_reg;
    logic signed [PW:0]    d_reg [LANES];
    logic signed [PW+1:0]  sum_reg;
    res_t                  res_reg;
    res_t                  res_next;

    always_ff @(posedge clk)
    begin
        func_reg <= func;
        neg_reg  <= neg;
        for (int k = 0; k < LANES; k++)
        begin
            as_reg[k] <= as_in[k];
            d_reg[k]  <= (PW+1)'(p[k]) - (PW+1)'(q[k]);
        end
        sum_reg <= (PW+2)'(p[0]) + (PW+2)'(p[1]) + (PW+2)'(p[2]);
    end

    always_comb
    begin
        sat_t                 t;
        logic signed [PW+1:0] sh;
        res_next = '0;
        t        = '0;
        sh       = '0;
        unique case (func_reg)
            FN_ADD, FN_SUB:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    t = sat66((PW+2)'(as_reg[k]));
                    res_next.r[k] = t.val;
                    res_next.ov   = res_next.ov | t.ov;
                end
            end
            FN_CROSS:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    sh = (PW+2)'(d_reg[k]) >>> FRAC_BITS;
                    t  = sat66(sh);
                    res_next.r[k] = t.val;
                    res_next.ov   = res_next.ov | t.ov;
                end
            end
            FN_DOT:
            begin
                sh = sum_reg >>> FRAC_BITS;
                t  = sat66(sh);
                res_next.sc = t.val;
                res_next.ov = t.ov;
            end
            FN_NORM:
            begin
                res_next.norm = 1'b1;
                res_next.neg  = neg_reg;
                res_next.zl   = (sum_reg[PW-1:0] == '0);
                if (res_next.zl)
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        res_next.r[k] = ONE_Q;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // squares sit in d with q forced to zero
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            m[k] = d_reg[k][PW-1:0];
        end
    end

    assign s   = sum_reg[PW-1:0];
    assign res = res_reg;

endmodule

@@ hw/rtl/v3alu_div.sv @@
`timescale 1ns / 1ps

module v3alu_div (
    input  logic                          clk,
    input  logic [v3alu_pkg::PW-1:0]      m,
    input  logic [v3alu_pkg::PW-1:0]      s,
    output logic [v3alu_pkg::QW-1:0]      quo
);
    import v3alu_pkg::*;

    logic [PW-1:0] rem_reg [DIV_STEPS];
    logic [PW-1:0] s_reg   [DIV_STEPS];
    logic [QW-1:0] q_reg   [DIV_STEPS];

    // m never exceeds s, so the first quotient bit is a plain compare
    always_ff @(posedge clk)
    begin
        s_reg[0] <= s;
        if (m >= s)
        begin
            rem_reg[0] <= m - s;
            q_reg[0]   <= QW'(1);
        end
        else
        begin
            rem_reg[0] <= m;
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 1; j < DIV_STEPS; j++)
    begin : g_step
        logic [PW:0] r2;
        logic [PW:0] df;

        assign r2 = {rem_reg[j-1], 1'b0};
        assign df = r2 - {1'b0, s_reg[j-1]};

        always_ff @(posedge clk)
        begin
            s_reg[j] <= s_reg[j-1];
            if (r2 >= {1'b0, s_reg[j-1]})
            begin
                rem_reg[j] <= df[PW-1:0];
                q_reg[j]   <= {q_reg[j-1][QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j] <= r2[PW-1:0];
                q_reg[j]   <= {q_reg[j-1][QW-2:0], 1'b0};
            end
        end
    end

    assign quo = q_reg[DIV_STEPS-1];

endmodule

@@ hw/rtl/v3alu_sqrt.sv @@
`timescale 1ns / 1ps

module v3alu_sqrt (
    input  logic                              clk,
    input  logic [v3alu_pkg::QW-1:0]          v,
    output logic [v3alu_pkg::SQ_STEPS-1:0]    root
);
    import v3alu_pkg::*;

    logic [SQ_IN_W-1:0]  v_reg    [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0] root_reg [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_step
        localparam int I = SQ_STEPS - 1 - j;
        logic [SQ_IN_W-1:0]  pv;
        logic [SQ_REM_W-1:0] prem;
        logic [SQ_STEPS-1:0] proot;
        logic [SQ_REM_W-1:0] r4;
        logic [SQ_REM_W-1:0] trial;

        if (j == 0)
        begin : g_first
            assign pv    = SQ_IN_W'(v);
            assign prem  = '0;
            assign proot = '0;
        end
        else
        begin : g_next
            assign pv    = v_reg[j-1];
            assign prem  = rem_reg[j-1];
            assign proot = root_reg[j-1];
        end

        // one result bit per stage, two radicand bits shifted in
        assign r4    = {prem[SQ_REM_W-3:0], pv[2*I+1 -: 2]};
        assign trial = SQ_REM_W'({proot, 2'b01});

        always_ff @(posedge clk)
        begin
            v_reg[j] <= pv;
            if (r4 >= trial)
            begin
                rem_reg[j]  <= r4 - trial;
                root_reg[j] <= {proot[SQ_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j]  <= r4;
                root_reg[j] <= {proot[SQ_STEPS-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1];

endmodule

@@ hw/rtl/vector3_alu_core.sv @@
`timescale 1ns / 1ps

// Three-component vector ALU on signed Q16.16 values: add, subtract, cross,
// dot and normalize of a. busy stays low, so an item is taken on every cycle
// that start is high, one per clock. Each item gives one result, marked by
// done for exactly one cycle; results leave in the order items came in and
// must be taken when shown. The latency is set by the normalize path: a
// 33-stage restoring divider followed by a 17-stage square root pipeline, one
// per lane, with the other operations carried alongside to keep order.

module vector3_alu_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          func,
    input  logic signed [31:0]  ax,
    input  logic signed [31:0]  ay,
    input  logic signed [31:0]  az,
    input  logic signed [31:0]  bx,
    input  logic signed [31:0]  by,
    input  logic signed [31:0]  bz,
    output logic                done,
    output logic signed [31:0]  rx,
    output logic signed [31:0]  ry,
    output logic signed [31:0]  rz,
    output logic signed [31:0]  scalar_out,
    output logic                zero_length,
    output logic                overflow
);
    import v3alu_pkg::*;

    logic [LATENCY-1:0]  vld_reg;
    func_t               func0_reg;
    logic signed [DW-1:0] a_reg [LANES];
    logic signed [DW-1:0] b_reg [LANES];

    logic signed [DW-1:0] x1 [LANES];
    logic signed [DW-1:0] y1 [LANES];
    logic signed [DW-1:0] x2 [LANES];
    logic signed [DW-1:0] y2 [LANES];
    logic signed [PW-1:0] p [LANES];
    logic signed [PW-1:0] q [LANES];

    func_t               func1_reg;
    logic signed [DW:0]  as1_reg [LANES];
    logic [LANES-1:0]    neg1_reg;

    logic [PW-1:0]       m [LANES];
    logic [PW-1:0]       s;
    res_t                res;
    res_t                res_dly_reg [DLY];
    logic [QW-1:0]       quo [LANES];
    logic [SQ_STEPS-1:0] root [LANES];

    logic [LANES-1:0][DW-1:0] r_next;
    logic [LANES-1:0][DW-1:0] r_reg;
    logic [DW-1:0]       sc_reg;
    logic                zl_reg;
    logic                ov_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            func0_reg <= func_t'(func);
            a_reg[0]  <= ax;
            a_reg[1]  <= ay;
            a_reg[2]  <= az;
            b_reg[0]  <= bx;
            b_reg[1]  <= by;
            b_reg[2]  <= bz;
        end
    end

    // operand routing into the three multiplier lanes
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            x1[k] = '0;
            y1[k] = '0;
            x2[k] = '0;
            y2[k] = '0;
        end
        unique case (func0_reg)
            FN_CROSS:
            begin
                x1[0] = a_reg[1]; y1[0] = b_reg[2]; x2[0] = b_reg[1]; y2[0] = a_reg[2];
                x1[1] = b_reg[0]; y1[1] = a_reg[2]; x2[1] = a_reg[0]; y2[1] = b_reg[2];
                x1[2] = a_reg[0]; y1[2] = b_reg[1]; x2[2] = b_reg[0]; y2[2] = a_reg[1];
            end
            FN_DOT:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    x1[k] = a_reg[k];
                    y1[k] = b_reg[k];
                end
            end
            FN_NORM:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    x1[k] = a_reg[k];
                    y1[k] = a_reg[k];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        func1_reg <= func0_reg;
        for (int k = 0; k < LANES; k++)
        begin
            neg1_reg[k] <= a_reg[k][DW-1];
            if (func0_reg == FN_SUB)
            begin
                as1_reg[k] <= (DW+1)'(a_reg[k]) - (DW+1)'(b_reg[k]);
            end
            else
            begin
                as1_reg[k] <= (DW+1)'(a_reg[k]) + (DW+1)'(b_reg[k]);
            end
        end
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        v3alu_mul_lane u_mul (
            .clk (clk),
            .x1  (x1[k]),
            .y1  (y1[k]),
            .x2  (x2[k]),
            .y2  (y2[k]),
            .p   (p[k]),
            .q   (q[k])
        );

        v3alu_div u_div (
            .clk (clk),
            .m   (m[k]),
            .s   (s),
            .quo (quo[k])
        );

        v3alu_sqrt u_sqrt (
            .clk  (clk),
            .v    (quo[k]),
            .root (root[k])
        );
    end

    v3alu_merge u_merge (
        .clk   (clk),
        .func  (func1_reg),
        .as_in (as1_reg),
        .neg   (neg1_reg),
        .p     (p),
        .q     (q),
        .m     (m),
        .s     (s),
        .res   (res)
    );

    always_ff @(posedge clk)
    begin
        res_dly_reg[0] <= res;
        for (int i = 1; i < DLY; i++)
        begin
            res_dly_reg[i] <= res_dly_reg[i-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (res_dly_reg[DLY-1].norm && !res_dly_reg[DLY-1].zl)
            begin
                if (res_dly_reg[DLY-1].neg[k])
                begin
                    r_next[k] = DW'(0) - DW'(root[k]);
                end
                else
                begin
                    r_next[k] = DW'(root[k]);
                end
            end
            else
            begin
                r_next[k] = res_dly_reg[DLY-1].r[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        sc_reg <= res_dly_reg[DLY-1].sc;
        zl_reg <= res_dly_reg[DLY-1].zl;
        ov_reg <= res_dly_reg[DLY-1].ov;
    end

    assign done        = vld_reg[LATENCY-1];
    assign rx          = r_reg[0];
    assign ry          = r_reg[1];
    assign rz          = r_reg[2];
    assign scalar_out  = sc_reg;
    assign zero_length = zl_reg;
    assign overflow    = ov_reg;

endmodule

@@ hw/rtl/v3alu_checker.sv @@
`timescale 1ns / 1ps

module v3alu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [2:0]          func,
    input logic signed [31:0]  ax,
    input logic signed [31:0]  ay,
    input logic signed [31:0]  az,
    input logic signed [31:0]  bx,
    input logic signed [31:0]  by,
    input logic signed [31:0]  bz,
    input logic                done,
    input logic signed [31:0]  rx,
    input logic signed [31:0]  ry,
    input logic signed [31:0]  rz,
    input logic signed [31:0]  scalar_out,
    input logic                zero_length,
    input logic                overflow
);
    import v3alu_pkg::*;

    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted item gave no result");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_length |-> rx == ONE_Q && ry == ONE_Q && rz == ONE_Q
            && scalar_out == 0 && !overflow)
        else $error("zero-length result malformed");

    a_dot_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && scalar_out != 0 |-> rx == 0 && ry == 0 && rz == 0 && !zero_length)
        else $error("scalar with vector result");

endmodule

bind vector3_alu_core v3alu_checker u_v3alu_checker (.*);

@@ dv/vector3_alu_checker.sv @@
`timescale 1ns / 1ps

module vector3_alu_checker
    import v3alu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         func,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] az,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by,
    input  logic signed [31:0] bz,
    input  logic               done,
    input  logic signed [31:0] rx,
    input  logic signed [31:0] ry,
    input  logic signed [31:0] rz,
    input  logic signed [31:0] scalar_out,
    input  logic               zero_length,
    input  logic               overflow,
    output int                 errors,
    output int                 pending,
    output int                 results_seen
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sc;
        logic        zl;
        logic        ov;
    } vec_result_t;

    vec_result_t expected_q[$];

    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ov);
        if (v > 128'sh7FFFFFFF)
        begin
            ov = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -128'sh80000000)
        begin
            ov = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // largest r with r*r <= v
    function automatic logic [63:0] int_sqrt(input logic [127:0] v);
        logic [127:0] r;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            if (((r | (128'd1 << b)) * (r | (128'd1 << b))) <= v)
                r = r | (128'd1 << b);
        end
        return r[63:0];
    endfunction

    function automatic vec_result_t compute_result(
        input logic [2:0] f,
        input logic signed [31:0] a0, a1, a2, b0, b1, b2
    );
        vec_result_t e;
        logic signed [127:0] p, q;
        logic [127:0] m0, m1, m2, s;
        logic [31:0] g;
        logic [63:0] v;
        logic ov;
        ov = 1'b0;
        e = '{default: '0};
        case (f)
            FN_ADD, FN_SUB:
            begin
                e.x = clamp32(f == FN_ADD ? 128'(a0) + 128'(b0) : 128'(a0) - 128'(b0), ov);
                e.y = clamp32(f == FN_ADD ? 128'(a1) + 128'(b1) : 128'(a1) - 128'(b1), ov);
                e.z = clamp32(f == FN_ADD ? 128'(a2) + 128'(b2) : 128'(a2) - 128'(b2), ov);
            end
            FN_CROSS:
            begin
                p = 128'(a1) * 128'(b2) - 128'(b1) * 128'(a2);
                e.x = clamp32(p >>> FRAC_BITS, ov);
                p = 128'(b0) * 128'(a2) - 128'(a0) * 128'(b2);
                e.y = clamp32(p >>> FRAC_BITS, ov);
                p = 128'(a0) * 128'(b1) - 128'(b0) * 128'(a1);
                e.z = clamp32(p >>> FRAC_BITS, ov);
            end
            FN_DOT:
            begin
                q = 128'(a0) * 128'(b0) + 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2);
                e.sc = clamp32(q >>> FRAC_BITS, ov);
            end
            FN_NORM:
            begin
                g = a0[31] ? -a0 : a0; m0 = 128'(g) * 128'(g);
                g = a1[31] ? -a1 : a1; m1 = 128'(g) * 128'(g);
                g = a2[31] ? -a2 : a2; m2 = 128'(g) * 128'(g);
                s = m0 + m1 + m2;
                if (s == 0)
                begin
                    e.zl = 1'b1;
                    e.x = ONE_Q;
                    e.y = ONE_Q;
                    e.z = ONE_Q;
                end
                else
                begin
                    v = int_sqrt((m0 << (2 * FRAC_BITS)) / s);
                    e.x = a0[31] ? -v[31:0] : v[31:0];
                    v = int_sqrt((m1 << (2 * FRAC_BITS)) / s);
                    e.y = a1[31] ? -v[31:0] : v[31:0];
                    v = int_sqrt((m2 << (2 * FRAC_BITS)) / s);
                    e.z = a2[31] ? -v[31:0] : v[31:0];
                end
            end
            default:
            begin
            end
        endcase
        e.ov = ov;
        return e;
    endfunction

    initial
    begin
        errors = 0;
        results_seen = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        vec_result_t e;
        if (rst_n)
        begin
            if (start && !busy)
                expected_q.push_back(compute_result(func, ax, ay, az, bx, by, bz));
            if (done)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: %h %h %h %h", $time,
                             rx, ry, rz, scalar_out);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (rx !== e.x || ry !== e.y || rz !== e.z || scalar_out !== e.sc ||
                        zero_length !== e.zl || overflow !== e.ov)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %h %h %h sc %h zl %b ov %b", $time,
                                 e.x, e.y, e.z, e.sc, e.zl, e.ov);
                        $display("%0t:          actual   %h %h %h sc %h zl %b ov %b", $time,
                                 rx, ry, rz, scalar_out, zero_length, overflow);
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb_vector3_alu_core.sv @@
`timescale 1ns / 1ps

module tb_vector3_alu_core;
    import v3alu_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         func;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic               done;
    logic signed [31:0] rx, ry, rz, scalar_out;
    logic               zero_length, overflow;
    int                 errors, pending, results_seen;
    int                 cycles;
    int                 sent;

    localparam int NUM_RANDOM = 1500;
    localparam int CYCLE_LIMIT = 40000;

    vector3_alu_core uut (.*);

    vector3_alu_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
            4: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
            5: return $urandom_range(0, 1) ? 32'h1 : 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [2:0] f, input logic [31:0] a0, a1, a2,
                             input logic [31:0] b0, b1, b2, input bit gaps);
        while (gaps && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        ax <= a0; ay <= a1; az <= a2;
        bx <= b0; by <= b1; bz <= b2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    initial
    begin
        logic [2:0] f;
        start = 1'b0;
        func = '0;
        {ax, ay, az, bx, by, bz} = '0;
        sent = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each operation, extremes, zero-length normalize, unused codes
        for (int k = 0; k <= 4; k++)
        begin
            send_item(3'(k), 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0);
            send_item(3'(k), 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
        end
        send_item(FN_NORM, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h1, 32'h5, 1'b0);
        send_item(FN_NORM, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(FN_NORM, 32'h00030000, 32'hFFFC0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(FN_NORM, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 1'b0);
        send_item(FN_DOT, 32'h00020000, 32'h00030000, 32'hFFFF8000,
                  32'h00010000, 32'hFFFF0000, 32'h00040000, 1'b0);
        for (int k = 5; k <= 7; k++)
            send_item(3'(k), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);

        // random part; the middle third runs back to back
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            f = ($urandom_range(0, 99) < 4) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
            send_item(f, pick_value(), pick_value(), pick_value(),
                      pick_value(), pick_value(), pick_value(),
                      !(n > NUM_RANDOM / 3 && n < 2 * NUM_RANDOM / 3));
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("%0d items sent, %0d results checked: all operations, extremes,", sent,
                 results_seen);
        $display("zero-length normalize and unused codes");
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/v3alu_pkg.sv
hw/rtl/v3alu_mul_lane.sv
hw/rtl/v3alu_merge.sv
hw/rtl/v3alu_div.sv
hw/rtl/v3alu_sqrt.sv
hw/rtl/vector3_alu_core.sv
hw/rtl/v3alu_checker.sv
dv/vector3_alu_checker.sv
dv/tb_vector3_alu_core.sv
